// ===== src/byte_matrix_permutation_engine_assert.svh =====
// Assertion macros for the byte matrix permutation engine.
// Depends on nothing; included by modules that carry assertions.
`ifndef BYTE_MATRIX_PERMUTATION_ENGINE_ASSERT_SVH
`define BYTE_MATRIX_PERMUTATION_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define BMPE_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define BMPE_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition");
`else
`define BMPE_ASSERT_IMPL(label, clk, rstn, prop)
`define BMPE_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== src/bmpe_pkg.sv =====
// Package for the byte matrix permutation engine: command codes and widths.
// No dependencies.
package bmpe_pkg;
    localparam int unsigned DIM_W = 9;
    localparam logic [3:0] CMD_WRITE     = 4'd0;
    localparam logic [3:0] CMD_READ      = 4'd1;
    localparam logic [3:0] CMD_CELLSWAP  = 4'd2;
    localparam logic [3:0] CMD_ROWSWAP   = 4'd3;
    localparam logic [3:0] CMD_COLSWAP   = 4'd4;
    localparam logic [3:0] CMD_ROWREV    = 4'd5;
    localparam logic [3:0] CMD_COLREV    = 4'd6;
    localparam logic [3:0] CMD_ROWROT    = 4'd7;
    localparam logic [3:0] CMD_COLROT    = 4'd8;
    localparam logic [3:0] CMD_NEIGHBOUR = 4'd9;
    localparam logic [3:0] CMD_ALLCOLS   = 4'd10;
    localparam logic [3:0] CMD_ALLROWS   = 4'd11;
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;
    typedef logic [DIM_W-1:0] dim_t;
    // request/answer between sequencer and the modulo unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        dim_t        divisor;
    } mod_req_t;
    typedef struct packed {
        logic done;
        dim_t remainder;
    } mod_rsp_t;
endpackage

// ===== src/bmpe_mod_unit.sv =====
// Restoring modulo unit: 32-bit dividend by 9-bit divisor, one bit a cycle.
// Depends on bmpe_pkg.
module bmpe_mod_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmpe_pkg::mod_req_t req,
    output bmpe_pkg::mod_rsp_t rsp
);
    import bmpe_pkg::*;
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [DIM_W:0] rem_reg, rem_next;
    dim_t        dv_reg, dv_next;
    logic        done_reg, done_next;
    logic [DIM_W:0] trial;
    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        dv_next = dv_reg;
        done_next = 1'b0;
        trial = {rem_reg[DIM_W-1:0], q_reg[31]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            q_next = req.dividend;
            rem_next = '0;
            dv_next = req.divisor;
        end else if (busy_reg) begin
            q_next = {q_reg[30:0], 1'b0};
            if (trial >= {1'b0, dv_reg}) begin
                rem_next = trial - {1'b0, dv_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        dv_reg <= dv_next;
    end
    assign rsp.done = done_reg;
    assign rsp.remainder = rem_reg[DIM_W-1:0];
endmodule

// ===== src/byte_matrix_permutation_engine.sv =====
// Byte matrix permutation engine. One command word in, one result word out.
// Commands run one at a time. Operands are first reduced by a bit-serial
// modulo unit. A command reduces one to four operands. The matrix lives in
// one single-port byte memory with a registered read. Every cell pair is
// plan, address, two reads and two writes, then a step. A write ends after
// plan, address and its write; a read after plan, address and two reads.
// Rotates run as chains of neighbour swaps: a line of n cells takes n-1
// swaps, and a whole-matrix move does this for every line. The result goes
// to an output register, so a waiting result word does not hold the
// engine. A finished command only waits when the previous word is still
// undelivered.
// Depends on bmpe_pkg, bmpe_mod_unit and the assertion header.
module byte_matrix_permutation_engine #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: command[3:0], arg_a[35:4], arg_b[67:36], arg_c[99:68],
    //        arg_d[131:100], invert[132], write_byte[140:133], zero fill
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: read_byte[7:0], status[8], zero fill
    output logic [15:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_wdata
);
    import bmpe_pkg::*;
    `include "byte_matrix_permutation_engine_assert.svh"

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned PW = 2 * DIM_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MOD  = 4'd1;
    localparam logic [3:0] ST_PLAN = 4'd2;
    localparam logic [3:0] ST_RD1  = 4'd3;
    localparam logic [3:0] ST_RD2  = 4'd4;
    localparam logic [3:0] ST_WR1  = 4'd5;
    localparam logic [3:0] ST_WR2  = 4'd6;
    localparam logic [3:0] ST_NEXT = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_ADR  = 4'd9;

    // store
    logic [7:0] mem [CAPACITY];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    dim_t rows_reg, cols_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= dim_t'(1);
            cols_reg <= dim_t'(1);
        end else if (cfg_we) begin
            if (cfg_index == REG_ROWS) rows_reg <= cfg_wdata;
            else cols_reg <= cfg_wdata;
        end
    end

    logic [3:0]  state_reg, state_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [31:0] op_reg [4];
    logic [31:0] op_next [4];
    logic        inv_reg, inv_next;
    logic [7:0]  wb_reg, wb_next;
    logic [1:0]  mi_reg, mi_next;
    dim_t        a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    // loop counters: k outer/element index, j inner position
    dim_t        k_reg, k_next, j_reg, j_next;
    dim_t        r1_reg, r1_next, c1_reg, c1_next, r2_reg, r2_next, c2_reg, c2_next;
    logic [7:0]  t1_reg, t1_next, t2_reg, t2_next;
    logic [7:0]  rd_reg, rd_next;
    logic        st_reg, st_next;
    // output register: valid flag and {status, read_byte}
    logic        mv_reg, mv_next;
    logic [8:0]  res_reg, res_next;
    logic [AW-1:0] ad1_reg, ad1_next, ad2_reg, ad2_next;
    logic [PW-1:0] p1_reg, p1_next, p2_reg, p2_next;

    mod_req_t mreq;
    mod_rsp_t mrsp;
    bmpe_mod_unit u_mod (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    logic [PW-1:0] prod;
    logic          dims_ok;
    logic          rot_dir;
    dim_t          rm1, cm1;
    assign prod = PW'(rows_reg) * PW'(cols_reg);
    assign rm1 = rows_reg - dim_t'(1);
    assign cm1 = cols_reg - dim_t'(1);
    assign rot_dir = ((cmd_reg == CMD_ALLCOLS || cmd_reg == CMD_ALLROWS)
                      ? op_reg[0][0] : op_reg[1][0]) ^ inv_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        for (int i = 0; i < 4; i++) op_next[i] = op_reg[i];
        inv_next = inv_reg; wb_next = wb_reg; mi_next = mi_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        k_next = k_reg; j_next = j_reg;
        r1_next = r1_reg; c1_next = c1_reg; r2_next = r2_reg; c2_next = c2_reg;
        t1_next = t1_reg; t2_next = t2_reg;
        rd_next = rd_reg; st_next = st_reg;
        mv_next = mv_reg; res_next = res_reg;
        if (mv_reg && m_tready) mv_next = 1'b0;
        ad1_next = ad1_reg; ad2_next = ad2_reg;
        p1_next = p1_reg; p2_next = p2_reg;
        mreq.start = 1'b0; mreq.dividend = '0; mreq.divisor = rows_reg;
        mem_we = 1'b0; mem_addr = ad1_reg; mem_wdata = t2_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = s_tdata[3:0];
                    op_next[0] = s_tdata[35:4];
                    op_next[1] = s_tdata[67:36];
                    op_next[2] = s_tdata[99:68];
                    op_next[3] = s_tdata[131:100];
                    inv_next = s_tdata[132];
                    wb_next = s_tdata[140:133];
                    rd_next = '0;
                    st_next = 1'b0;
                    if (prod > PW'(CAPACITY)) begin
                        st_next = 1'b1;
                        state_next = ST_OUT;
                    end else if (rows_reg == '0 || cols_reg == '0
                                 || s_tdata[3:0] > CMD_ALLROWS) begin
                        state_next = ST_OUT;
                    end else begin
                        mi_next = 2'd0;
                        mreq.start = 1'b1;
                        mreq.dividend = s_tdata[35:4];
                        mreq.divisor = (s_tdata[3:0] == CMD_COLSWAP
                                        || s_tdata[3:0] == CMD_COLREV
                                        || s_tdata[3:0] == CMD_COLROT)
                                       ? cols_reg : rows_reg;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                // operand order: a, b, c, d; b is a column except for rowswap,
                // c is a row, d a column
                if (mrsp.done) begin
                    case (mi_reg)
                        2'd0: a_next = mrsp.remainder;
                        2'd1: b_next = mrsp.remainder;
                        2'd2: c_next = mrsp.remainder;
                        default: d_next = mrsp.remainder;
                    endcase
                    mi_next = mi_reg + 2'd1;
                    if (mi_reg == 2'd3
                        || (mi_reg == 2'd1 && cmd_reg != CMD_CELLSWAP)
                        || (mi_reg == 2'd0 && (cmd_reg == CMD_ROWREV
                            || cmd_reg == CMD_COLREV || cmd_reg == CMD_ROWROT
                            || cmd_reg == CMD_COLROT || cmd_reg == CMD_ALLCOLS
                            || cmd_reg == CMD_ALLROWS))) begin
                        state_next = ST_PLAN;
                        k_next = '0;
                        j_next = '0;
                    end else begin
                        mreq.start = 1'b1;
                        mreq.dividend = op_reg[mi_reg + 2'd1];
                        mreq.divisor = (mi_reg == 2'd2
                                        || (mi_reg == 2'd0 && cmd_reg != CMD_ROWSWAP))
                                       ? cols_reg : rows_reg;
                    end
                end
            end
            ST_PLAN: begin
                // choose the next pair of cells
                state_next = ST_ADR;
                case (cmd_reg)
                    CMD_WRITE, CMD_READ: begin
                        r1_next = a_reg; c1_next = b_reg;
                        r2_next = a_reg; c2_next = b_reg;
                    end
                    CMD_CELLSWAP: begin
                        r1_next = a_reg; c1_next = b_reg;
                        r2_next = c_reg; c2_next = d_reg;
                    end
                    CMD_ROWSWAP: begin
                        r1_next = a_reg; c1_next = k_reg;
                        r2_next = b_reg; c2_next = k_reg;
                        if (k_reg >= cols_reg) state_next = ST_OUT;
                    end
                    CMD_COLSWAP: begin
                        r1_next = k_reg; c1_next = a_reg;
                        r2_next = k_reg; c2_next = b_reg;
                        if (k_reg >= rows_reg) state_next = ST_OUT;
                    end
                    CMD_ROWREV: begin
                        r1_next = a_reg; c1_next = k_reg;
                        r2_next = a_reg; c2_next = cm1 - k_reg;
                        if (k_reg >= (cols_reg >> 1)) state_next = ST_OUT;
                    end
                    CMD_COLREV: begin
                        r1_next = k_reg; c1_next = a_reg;
                        r2_next = rm1 - k_reg; c2_next = a_reg;
                        if (k_reg >= (rows_reg >> 1)) state_next = ST_OUT;
                    end
                    CMD_NEIGHBOUR: begin
                        r1_next = a_reg; c1_next = b_reg;
                        r2_next = a_reg; c2_next = b_reg;
                        case (op_reg[2][1:0])
                            DIR_UP: r2_next = (a_reg == '0) ? rm1 : a_reg - dim_t'(1);
                            DIR_DOWN: r2_next = (a_reg == rm1) ? '0 : a_reg + dim_t'(1);
                            DIR_LEFT: c2_next = (b_reg == '0) ? cm1 : b_reg - dim_t'(1);
                            default: c2_next = (b_reg == cm1) ? '0 : b_reg + dim_t'(1);
                        endcase
                    end
                    default: begin
                        // rotates as a chain of adjacent swaps:
                        // line index L, positions j and j+1 (or reversed)
                        dim_t line, len;
                        logic colw;
                        colw = (cmd_reg == CMD_COLROT || cmd_reg == CMD_ALLCOLS);
                        line = (cmd_reg == CMD_ROWROT || cmd_reg == CMD_COLROT)
                               ? a_reg : k_reg;
                        len = colw ? rows_reg : cols_reg;
                        if ((cmd_reg == CMD_ROWROT || cmd_reg == CMD_COLROT)
                            ? (k_reg != '0)
                            : (k_reg >= (colw ? cols_reg : rows_reg))) begin
                            state_next = ST_OUT;
                        end else if (j_reg + dim_t'(1) >= len) begin
                            k_next = k_reg + dim_t'(1);
                            j_next = '0;
                            state_next = ST_PLAN;
                        end else begin
                            dim_t p, q;
                            // dir 0: swap (j,j+1) ascending; dir 1: from the end
                            p = rot_dir ? (len - dim_t'(1) - j_reg) : j_reg;
                            q = rot_dir ? (len - dim_t'(2) - j_reg) : j_reg + dim_t'(1);
                            r1_next = colw ? p : line; c1_next = colw ? line : p;
                            r2_next = colw ? q : line; c2_next = colw ? line : q;
                        end
                    end
                endcase
                p1_next = PW'(r1_next) * PW'(cols_reg);
                p2_next = PW'(r2_next) * PW'(cols_reg);
            end
            ST_ADR: begin
                ad1_next = AW'(p1_reg + PW'(c1_reg));
                ad2_next = AW'(p2_reg + PW'(c2_reg));
                state_next = ST_RD1;
            end
            ST_RD1: begin
                mem_addr = ad1_reg;
                if (cmd_reg == CMD_WRITE) begin
                    mem_we = 1'b1;
                    mem_wdata = wb_reg;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2: begin
                mem_addr = ad2_reg;
                t1_next = mem_rdata;
                if (cmd_reg == CMD_READ) begin
                    rd_next = mem_rdata;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_WR1;
                end
            end
            ST_WR1: begin
                t2_next = mem_rdata;
                mem_addr = ad1_reg;
                mem_we = 1'b1;
                mem_wdata = mem_rdata;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                mem_addr = ad2_reg;
                mem_we = 1'b1;
                mem_wdata = t1_reg;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (cmd_reg == CMD_CELLSWAP || cmd_reg == CMD_NEIGHBOUR) begin
                    state_next = ST_OUT;
                end else if (cmd_reg == CMD_ROWROT || cmd_reg == CMD_COLROT
                             || cmd_reg == CMD_ALLCOLS || cmd_reg == CMD_ALLROWS) begin
                    j_next = j_reg + dim_t'(1);
                    state_next = ST_PLAN;
                end else begin
                    k_next = k_reg + dim_t'(1);
                    state_next = ST_PLAN;
                end
            end
            ST_OUT: begin
                // hand the word to the output register once it is free
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    res_next = {st_reg, rd_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
        cmd_reg <= cmd_next;
        for (int i = 0; i < 4; i++) op_reg[i] <= op_next[i];
        inv_reg <= inv_next; wb_reg <= wb_next; mi_reg <= mi_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        k_reg <= k_next; j_reg <= j_next;
        r1_reg <= r1_next; c1_reg <= c1_next; r2_reg <= r2_next; c2_reg <= c2_next;
        t1_reg <= t1_next; t2_reg <= t2_next;
        rd_reg <= rd_next; st_reg <= st_next;
        res_reg <= res_next;
        ad1_reg <= ad1_next; ad2_reg <= ad2_next;
        p1_reg <= p1_next; p2_reg <= p2_next;
    end

    assign dims_ok = (prod <= PW'(CAPACITY));
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata = {7'd0, res_reg};

    `BMPE_ASSERT_IMPL(a_out_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> m_tvalid)
    `BMPE_ASSERT_IMPL(a_out_stable, aclk, aresetn,
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
    `BMPE_ASSERT_NEVER(a_store_ok, aclk, aresetn, mem_we && !dims_ok)
    `BMPE_ASSERT_IMPL(a_status_read, aclk, aresetn,
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
endmodule

// ===== sim/byte_matrix_permutation_engine_tb.sv =====
// Testbench for byte_matrix_permutation_engine: directed and random command streams
// checked word by word against an in-bench matrix predictor.
// Depends on bmpe_pkg and the engine RTL.
module byte_matrix_permutation_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmpe_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // tdata: command, arg_a, arg_b, arg_c, arg_d, invert, write_byte, zero fill
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // tdata: read_byte, status, zero fill
    logic [15:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [8:0]   cfg_wdata;

    byte_matrix_permutation_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic [7:0] rd;
        logic       status;
    } answer_t;

    // shadow matrix: bit 8 marks a cell holding a written byte
    logic [8:0]  shadow_cells [256];
    int unsigned rows_in_use, cols_in_use;
    answer_t     pending_answers [$];
    int          mismatches;
    int          send_idle_pct, recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned cell_idx(int unsigned r, int unsigned c);
        return (r * cols_in_use + c) % 256;
    endfunction

    function automatic void swap_at(int unsigned r1, int unsigned c1,
                                    int unsigned r2, int unsigned c2);
        int unsigned i, j;
        logic [8:0] t;
        i = cell_idx(r1, c1);
        j = cell_idx(r2, c2);
        t = shadow_cells[i];
        shadow_cells[i] = shadow_cells[j];
        shadow_cells[j] = t;
    endfunction

    // Rotate a row (horiz=1) or column by one place; dir 0 = left/up.
    function automatic void rotate_line(bit horiz, int unsigned line, bit dir);
        int unsigned n, k;
        logic [8:0] t;
        n = horiz ? cols_in_use : rows_in_use;
        if (dir == 1'b0) begin
            t = shadow_cells[horiz ? cell_idx(line, 0) : cell_idx(0, line)];
            for (k = 1; k < n; k++)
                if (horiz) shadow_cells[cell_idx(line, k-1)] = shadow_cells[cell_idx(line, k)];
                else       shadow_cells[cell_idx(k-1, line)] = shadow_cells[cell_idx(k, line)];
            shadow_cells[horiz ? cell_idx(line, n-1) : cell_idx(n-1, line)] = t;
        end else begin
            t = shadow_cells[horiz ? cell_idx(line, n-1) : cell_idx(n-1, line)];
            for (k = n-1; k > 0; k--)
                if (horiz) shadow_cells[cell_idx(line, k)] = shadow_cells[cell_idx(line, k-1)];
                else       shadow_cells[cell_idx(k, line)] = shadow_cells[cell_idx(k-1, line)];
            shadow_cells[horiz ? cell_idx(line, 0) : cell_idx(0, line)] = t;
        end
    endfunction

    // Apply one command to the shadow matrix and return the expected answer.
    function automatic answer_t apply_command(logic [3:0] cmd, logic [31:0] a,
            logic [31:0] b, logic [31:0] c, logic [31:0] d, logic inv,
            logic [7:0] wbyte);
        answer_t ans;
        int unsigned R, C, k, r0, c0, r1, c1;
        R = rows_in_use;
        C = cols_in_use;
        ans = '0;
        if (R * C > 256) begin
            ans.status = 1'b1;
            return ans;
        end
        if (R == 0 || C == 0) return ans;
        case (cmd)
            CMD_WRITE:    shadow_cells[cell_idx(a % R, b % C)] = {1'b1, wbyte};
            CMD_READ:     ans.rd = shadow_cells[cell_idx(a % R, b % C)][7:0];
            CMD_CELLSWAP: swap_at(a % R, b % C, c % R, d % C);
            CMD_ROWSWAP:  for (k = 0; k < C; k++) swap_at(a % R, k, b % R, k);
            CMD_COLSWAP:  for (k = 0; k < R; k++) swap_at(k, a % C, k, b % C);
            CMD_ROWREV:   for (k = 0; k < C/2; k++) swap_at(a % R, k, a % R, C-1-k);
            CMD_COLREV:   for (k = 0; k < R/2; k++) swap_at(k, a % C, R-1-k, a % C);
            CMD_ROWROT:   rotate_line(1'b1, a % R, b[0] ^ inv);
            CMD_COLROT:   rotate_line(1'b0, a % C, b[0] ^ inv);
            CMD_NEIGHBOUR: begin
                r0 = a % R; c0 = b % C; r1 = r0; c1 = c0;
                case (c[1:0])
                    DIR_UP:   r1 = (r0 == 0) ? R - 1 : r0 - 1;
                    DIR_DOWN: r1 = (r0 + 1) % R;
                    DIR_LEFT: c1 = (c0 == 0) ? C - 1 : c0 - 1;
                    default:  c1 = (c0 + 1) % C;
                endcase
                swap_at(r0, c0, r1, c1);
            end
            CMD_ALLCOLS:  for (k = 0; k < C; k++) rotate_line(1'b0, k, a[0] ^ inv);
            CMD_ALLROWS:  for (k = 0; k < R; k++) rotate_line(1'b1, k, a[0] ^ inv);
            default: ;
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
        $display("%0t mismatch %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Send one command word. A read of a never-written cell becomes a write.
    task automatic send_command(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
            logic [31:0] c, logic [31:0] d, logic inv, logic [7:0] wbyte);
        int gap;
        answer_t ans;
        if (cmd == CMD_READ && rows_in_use * cols_in_use <= 256 && rows_in_use != 0
                && cols_in_use != 0
                && !shadow_cells[cell_idx(a % rows_in_use, b % cols_in_use)][8])
            cmd = CMD_WRITE;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, wbyte, inv, d, c, b, a, cmd};
        // tready is stable at the falling edge; accept on the following rise
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        ans = apply_command(cmd, a, b, c, d, inv, wbyte);
        pending_answers.push_back(ans);
    endtask

    task automatic drain_and_configure(int unsigned rows, int unsigned cols);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= REG_ROWS; cfg_wdata <= rows[8:0];
        @(posedge aclk);
        cfg_index <= REG_COLS; cfg_wdata <= cols[8:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        rows_in_use = rows[8:0];
        cols_in_use = cols[8:0];
    endtask

    // Receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checker: a word moves at the rise after a falling edge with both high.
    initial begin
        answer_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[8:0], 9'h0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[7:0] !== want.rd)
                        report_mismatch("read_byte", {1'b0, m_tdata[7:0]}, {1'b0, want.rd});
                    if (m_tdata[8] !== want.status)
                        report_mismatch("status", {8'b0, m_tdata[8]}, {8'b0, want.status});
                end
            end
        end
    end

    // Directed corners on a 4x4 matrix: extremes, every command, edge wraps.
    task automatic test_directed();
        drain_and_configure(4, 4);
        send_command(CMD_WRITE, 0, 0, 0, 0, 0, 8'h00);
        send_command(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 8'hFF);
        send_command(CMD_WRITE, 0, 3, 0, 0, 1, 8'hA5);
        send_command(CMD_WRITE, 3, 0, 0, 0, 0, 8'h5A);
        send_command(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 8'h00);
        send_command(CMD_CELLSWAP, 0, 0, 3, 3, 0, 0);
        send_command(CMD_ROWSWAP, 0, 3, 0, 0, 0, 0);
        send_command(CMD_COLSWAP, 0, 7, 0, 0, 0, 0);
        send_command(CMD_ROWREV, 3, 0, 0, 0, 0, 0);
        send_command(CMD_COLREV, 0, 0, 0, 0, 0, 0);
        send_command(CMD_ROWROT, 0, 0, 0, 0, 0, 0);
        send_command(CMD_ROWROT, 0, 0, 0, 0, 1, 0);
        send_command(CMD_COLROT, 3, 1, 0, 0, 0, 0);
        // neighbour wraps off every edge
        send_command(CMD_NEIGHBOUR, 0, 0, DIR_UP, 0, 0, 0);
        send_command(CMD_NEIGHBOUR, 3, 3, DIR_DOWN, 0, 0, 0);
        send_command(CMD_NEIGHBOUR, 0, 0, DIR_LEFT, 0, 0, 0);
        send_command(CMD_NEIGHBOUR, 3, 3, 32'hFFFF_FFFF, 0, 0, 0);
        send_command(CMD_ALLCOLS, 1, 0, 0, 0, 0, 0);
        send_command(CMD_ALLROWS, 0, 0, 0, 0, 1, 0);
        send_command(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1, 8'hFF);
        send_command(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_command(CMD_READ, 3, 3, 0, 0, 0, 0);
        send_command(CMD_READ, 0, 3, 0, 0, 0, 0);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(20);
        endcase
    endfunction

    // Random commands over a sweep of shapes, including zero and oversize ones.
    task automatic test_random_shapes(int s_pct, int r_pct);
        int unsigned shapes [10][2] = '{'{16, 16}, '{4, 8}, '{1, 256}, '{256, 1},
            '{3, 5}, '{0, 7}, '{17, 16}, '{511, 511}, '{2, 2}, '{1, 1}};
        logic [3:0] cmd;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        foreach (shapes[i]) begin
            drain_and_configure(shapes[i][0], shapes[i][1]);
            repeat (38) begin
                // writes and reads dominate, whole-matrix moves kept rarer
                case ($urandom_range(9))
                    0, 1:    cmd = CMD_WRITE;
                    2, 3:    cmd = CMD_READ;
                    4:       cmd = 4'($urandom_range(12, 15));
                    5:       cmd = 4'($urandom_range(CMD_ALLCOLS, CMD_ALLROWS));
                    default: cmd = 4'($urandom_range(CMD_CELLSWAP, CMD_NEIGHBOUR));
                endcase
                send_command(cmd, pick_operand(), pick_operand(), pick_operand(),
                             pick_operand(), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROWS;
        cfg_wdata = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rows_in_use = 1;
        cols_in_use = 1;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_shapes(30, 87);
        test_random_shapes(87, 30);
        test_random_shapes(0, 0);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/bmpe_pkg.sv
src/bmpe_mod_unit.sv
src/byte_matrix_permutation_engine.sv
sim/byte_matrix_permutation_engine_tb.sv
